// File: hw/rtl/cht_pkg.sv
// Shared types and constants for the chained hash table engine.
// No dependencies.
`default_nettype none
package cht_pkg;
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_LOOKUP = 3'd1;
  localparam logic [2:0] CMD_COUNT  = 3'd2;
  localparam logic [2:0] CMD_DUMP   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_SLOT_BUSY = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [6:0] NIL = 7'd64;

  typedef logic [31:0] key_t;
  typedef logic [6:0]  ptr_t;
endpackage
`default_nettype wire

// File: hw/rtl/cht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                        clk,
  input  wire                                        we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                           wdata,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/cht_mod.sv
// Key modulo bucket count by reciprocal multiplication: three 32x16 partial
// products, one back-multiply and one correcting subtract. No dependencies.
`default_nettype none
module cht_mod #(
  parameter int BUCKETS = 1024
) (
  input  wire                                            clk,
  input  wire                                            rst,
  input  wire                                            start,
  input  wire  [31:0]                                    dividend,
  output logic                                           done,
  output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] remainder
);
  localparam int AW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int RW = AW + 1;
  // floor(2^44 / BUCKETS); quotient estimate is low by at most one
  localparam logic [47:0] RECIP = 48'((64'd1 << 44) / 64'(BUCKETS));
  localparam logic [12:0] BK = 13'(BUCKETS);

  logic          run;
  logic [2:0]    step;
  logic [31:0]   x;
  logic [75:0]   acc;
  logic [RW-1:0] r;
  logic [15:0]   slc;
  logic [47:0]   prod;
  logic [75:0]   term;
  logic [31:0]   qb;
  logic [31:0]   diff;

  always_comb begin
    case (step[1:0])
      2'd0:    slc = RECIP[15:0];
      2'd1:    slc = RECIP[31:16];
      2'd2:    slc = RECIP[47:32];
      default: slc = '0;
    endcase
  end

  assign prod = {16'b0, x} * {32'b0, slc};
  assign term = {28'b0, prod} << {step[1:0], 4'b0};
  assign qb   = acc[75:44] * {19'b0, BK};
  assign diff = x - qb;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        x    <= dividend;
        acc  <= '0;
      end else if (run) begin
        step <= step + 3'd1;
        if (step inside {[3'd0:3'd2]}) begin
          acc <= acc + term;
        end else if (step == 3'd3) begin
          r <= diff[RW-1:0];
        end else begin
          remainder <= (r >= RW'(BUCKETS)) ? AW'(r - RW'(BUCKETS)) : AW'(r);
          run       <= 1'b0;
          done      <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/chained_hash_table_engine.sv
// Chained hash table engine: command sequencer over bucket and node memories.
// Uses cht_pkg, cht_ram, cht_mod.
// Insert: modulo, head read, link. Lookup: modulo, head read, then a compare per chain node walked.
// Count, refused insert, empty dump: result registered in the cycle after start. Dump: one
// scan of node_key per emitted node. Clear: sweeps every bucket head to NIL. Reset runs
// the same sweep with busy high; results cannot be stalled.
`default_nettype none
module chained_hash_table_engine #(
  parameter int BUCKETS = 1024,
  parameter int NODES   = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  command,
  input  wire  [31:0] key,
  input  wire  [5:0]  node_slot,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  found_slot,
  output logic [31:0] found_key,
  output logic [6:0]  node_count,
  output logic        last
);
  localparam int AW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int NW = $clog2(NODES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_HREQ  = 4'd3;
  localparam logic [3:0] S_HEAD  = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_WCMP  = 4'd6;
  localparam logic [3:0] S_DSCAN = 4'd7;

  logic [3:0]        state;
  logic [2:0]        cmd_q;
  cht_pkg::key_t     key_q;
  logic [NW-1:0]     slot_q;
  logic [AW-1:0]     bidx;
  logic [AW-1:0]     clr_cnt;
  logic              clr_emit;
  logic [NODES-1:0]  used;
  logic [6:0]        total;
  cht_pkg::ptr_t     cur;
  logic [6:0]        steps;
  logic [6:0]        ridx;
  logic              p_v;
  logic [NW-1:0]     p_idx;
  logic              first;
  cht_pkg::key_t     prev_key;
  logic [NW-1:0]     prev_slot;
  logic              best_v;
  cht_pkg::key_t     best_key;
  logic [NW-1:0]     best_slot;
  logic [6:0]        emitted;

  logic              accept;
  logic              slot_ok;
  logic              mod_start;
  logic              mod_done;
  logic [AW-1:0]     mod_rem;
  logic              b_we;
  logic [AW-1:0]     b_waddr;
  cht_pkg::ptr_t     b_wdata;
  cht_pkg::ptr_t     b_rdata;
  logic              n_we;
  logic [NW-1:0]     n_raddr;
  cht_pkg::key_t     k_rdata;
  cht_pkg::ptr_t     x_rdata;
  logic              cand;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign slot_ok = ({1'b0, node_slot} < 7'(NODES)) && !used[node_slot[NW-1:0]];
  assign mod_start = accept && ((command == cht_pkg::CMD_INSERT && slot_ok) ||
                                command == cht_pkg::CMD_LOOKUP);

  always_comb begin
    b_we    = 1'b0;
    b_waddr = bidx;
    b_wdata = {1'b0, 6'(slot_q)};
    n_we    = 1'b0;
    n_raddr = ridx[NW-1:0];
    if (state == S_CLR) begin
      b_we    = 1'b1;
      b_waddr = clr_cnt;
      b_wdata = cht_pkg::NIL;
    end else if (state == S_HEAD && cmd_q == cht_pkg::CMD_INSERT) begin
      b_we = 1'b1;
      n_we = 1'b1;
    end
    if (state == S_WALK) begin
      n_raddr = cur[NW-1:0];
    end
  end

  assign cand = used[p_idx] &&
                (first || {k_rdata, p_idx} > {prev_key, prev_slot}) &&
                (!best_v || {k_rdata, p_idx} < {best_key, best_slot});

  cht_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(key),
    .done(mod_done), .remainder(mod_rem)
  );

  cht_ram #(.WIDTH(7), .DEPTH(BUCKETS)) u_bucket_head (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(bidx), .rdata(b_rdata)
  );

  cht_ram #(.WIDTH(32), .DEPTH(NODES)) u_node_key (
    .clk(clk), .we(n_we), .waddr(slot_q), .wdata(key_q),
    .raddr(n_raddr), .rdata(k_rdata)
  );

  cht_ram #(.WIDTH(7), .DEPTH(NODES)) u_node_next (
    .clk(clk), .we(n_we), .waddr(slot_q), .wdata(b_rdata),
    .raddr(n_raddr), .rdata(x_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      clr_emit <= 1'b0;
      used     <= '0;
      total    <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q  <= command;
            key_q  <= key;
            slot_q <= node_slot[NW-1:0];
            case (command)
              cht_pkg::CMD_INSERT: begin
                if (slot_ok) begin
                  state <= S_MOD;
                end else begin
                  done       <= 1'b1;
                  status     <= cht_pkg::ST_SLOT_BUSY;
                  found_slot <= node_slot;
                  found_key  <= '0;
                  node_count <= total;
                  last       <= 1'b1;
                end
              end
              cht_pkg::CMD_LOOKUP: state <= S_MOD;
              cht_pkg::CMD_COUNT: begin
                done       <= 1'b1;
                status     <= cht_pkg::ST_OK;
                found_slot <= '0;
                found_key  <= '0;
                node_count <= total;
                last       <= 1'b1;
              end
              cht_pkg::CMD_DUMP: begin
                if (total == 7'd0) begin
                  done       <= 1'b1;
                  status     <= cht_pkg::ST_EMPTY;
                  found_slot <= '0;
                  found_key  <= '0;
                  node_count <= '0;
                  last       <= 1'b1;
                end else begin
                  state   <= S_DSCAN;
                  ridx    <= '0;
                  p_v     <= 1'b0;
                  first   <= 1'b1;
                  best_v  <= 1'b0;
                  emitted <= '0;
                end
              end
              cht_pkg::CMD_CLEAR: begin
                state    <= S_CLR;
                clr_cnt  <= '0;
                clr_emit <= 1'b1;
                used     <= '0;
                total    <= '0;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(BUCKETS - 1)) begin
            state <= S_IDLE;
            if (clr_emit) begin
              done       <= 1'b1;
              status     <= cht_pkg::ST_OK;
              found_slot <= '0;
              found_key  <= '0;
              node_count <= '0;
              last       <= 1'b1;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bidx  <= mod_rem;
            state <= S_HREQ;
          end
        end
        S_HREQ: state <= S_HEAD;
        S_HEAD: begin
          if (cmd_q == cht_pkg::CMD_INSERT) begin
            used[slot_q] <= 1'b1;
            total        <= total + 7'd1;
            done         <= 1'b1;
            status       <= cht_pkg::ST_OK;
            found_slot   <= 6'(slot_q);
            found_key    <= key_q;
            node_count   <= total + 7'd1;
            last         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            cur   <= b_rdata;
            steps <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (cur >= 7'(NODES) || steps == 7'(NODES)) begin
            done       <= 1'b1;
            status     <= cht_pkg::ST_NOT_FOUND;
            found_slot <= '0;
            found_key  <= '0;
            node_count <= total;
            last       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_WCMP;
          end
        end
        S_WCMP: begin
          if (k_rdata == key_q) begin
            done       <= 1'b1;
            status     <= cht_pkg::ST_OK;
            found_slot <= cur[5:0];
            found_key  <= key_q;
            node_count <= total;
            last       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            cur   <= x_rdata;
            steps <= steps + 7'd1;
            state <= S_WALK;
          end
        end
        S_DSCAN: begin
          if (ridx < 7'(NODES)) begin
            p_v   <= 1'b1;
            p_idx <= ridx[NW-1:0];
            ridx  <= ridx + 7'd1;
          end else begin
            p_v <= 1'b0;
          end
          if (p_v && cand) begin
            best_v    <= 1'b1;
            best_key  <= k_rdata;
            best_slot <= p_idx;
          end
          if (ridx == 7'(NODES) && !p_v) begin
            done       <= 1'b1;
            status     <= cht_pkg::ST_OK;
            found_slot <= 6'(best_slot);
            found_key  <= best_key;
            node_count <= total;
            last       <= (emitted + 7'd1 == total);
            prev_key   <= best_key;
            prev_slot  <= best_slot;
            first      <= 1'b0;
            best_v     <= 1'b0;
            emitted    <= emitted + 7'd1;
            ridx       <= '0;
            if (emitted + 7'd1 == total) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
